>>> hdl/mcp_pkg.sv
// Shared types, constants and helpers of the median-cut palette block.
// No dependencies.
package mcp_pkg;

    localparam logic [1:0]  CH_RED   = 2'd0;
    localparam logic [1:0]  CH_GREEN = 2'd1;
    localparam logic [1:0]  CH_BLUE  = 2'd2;
    localparam logic [10:0] KEY_SPAN = 11'd1530;
    localparam logic        CFG_PALETTE_SIZE = 1'b0;
    localparam logic        CFG_LUMA_MIN     = 1'b1;

    typedef struct packed {
        logic       last;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [5:0] entry_index;
        logic [7:0] red_mean;
        logic [7:0] green_mean;
        logic [7:0] blue_mean;
        logic       empty_box;
        logic       pixels_dropped;
        logic       last_entry;
    } result_t;

    function automatic logic [7:0] chan_of(input logic [23:0] px, input logic [1:0] sel);
        logic [7:0] v;
        case (sel)
            CH_RED:   v = px[23:16];
            CH_GREEN: v = px[15:8];
            default:  v = px[7:0];
        endcase
        return v;
    endfunction

endpackage

>>> hdl/mcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/mcp_front.sv
// Front queue: accepts pixel items and holds up to two for the engine.
// Depends on mcp_pkg.
module mcp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  mcp_pkg::pixel_t item_in,
    output logic            item_valid,
    output mcp_pkg::pixel_t item_out,
    input  logic            item_take
);

    mcp_pkg::pixel_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, rd_reg;
    logic       do_push, do_take;

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item_out   = slot_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_take    = item_take && item_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_take)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!do_push && do_take)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_reg <= !wr_reg;
            end
            if (do_take)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= item_in;
        end
    end

endmodule

>>> hdl/mcp_divider.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module mcp_divider #(
    parameter int DW = 21,
    parameter int VW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int BCW = $clog2(DW + 1);

    logic [DW-1:0]  dvd_reg;
    logic [VW-1:0]  rem_reg;
    logic [VW-1:0]  dsr_reg;
    logic [BCW-1:0] bit_reg;
    logic           busy_reg, done_reg;
    logic [VW:0]    trial;
    logic           ge;

    assign trial    = {rem_reg, dvd_reg[DW-1]};
    assign ge       = (trial >= {1'b0, dsr_reg});
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= '0;
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg + BCW'(1);
                if (bit_reg == BCW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? VW'(trial - {1'b0, dsr_reg}) : trial[VW-1:0];
            dvd_reg <= {dvd_reg[DW-2:0], ge};
        end
    end

endmodule

>>> hdl/mcp_engine.sv
// Back engine: stores pixels, trims, splits boxes by counting sort, emits means.
// Depends on mcp_pkg, mcp_ram and mcp_divider.
module mcp_engine #(
    parameter int MAX_PIXELS = 4096,
    parameter int MAX_COLORS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  mcp_pkg::pixel_t  item,
    output logic             item_take,
    input  logic [6:0]       palette_size,
    input  logic [9:0]       luma_min,
    output logic             res_valid,
    output mcp_pkg::result_t res,
    input  logic             res_take
);

    localparam int AW  = $clog2(MAX_PIXELS);
    localparam int CW  = $clog2(MAX_PIXELS + 1);
    localparam int BW  = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int NW  = $clog2(MAX_COLORS + 1);
    localparam int SW  = CW + 8;

    typedef enum logic [28:0] {
        S_IDLE     = 29'd1 << 0,
        S_TRIM_RD  = 29'd1 << 1,
        S_TRIM_CHK = 29'd1 << 2,
        S_INIT     = 29'd1 << 3,
        S_LOOP     = 29'd1 << 4,
        S_BOX      = 29'd1 << 5,
        S_MM_RD    = 29'd1 << 6,
        S_MM_USE   = 29'd1 << 7,
        S_AXIS     = 29'd1 << 8,
        S_CLR      = 29'd1 << 9,
        S_H_RD     = 29'd1 << 10,
        S_H_B      = 29'd1 << 11,
        S_H_W      = 29'd1 << 12,
        S_P_RD     = 29'd1 << 13,
        S_P_W      = 29'd1 << 14,
        S_S_RD     = 29'd1 << 15,
        S_S_B      = 29'd1 << 16,
        S_S_W      = 29'd1 << 17,
        S_C_RD     = 29'd1 << 18,
        S_C_W      = 29'd1 << 19,
        S_WLO      = 29'd1 << 20,
        S_WHI      = 29'd1 << 21,
        S_E_BOX    = 29'd1 << 22,
        S_E_GET    = 29'd1 << 23,
        S_E_RD     = 29'd1 << 24,
        S_E_ACC    = 29'd1 << 25,
        S_DIV_GO   = 29'd1 << 26,
        S_DIV_WAIT = 29'd1 << 27,
        S_OUT      = 29'd1 << 28
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] run_reg, run_next;
    logic [23:0]   px_reg, px_next;
    logic [7:0]    bkt_reg, bkt_next;
    logic [7:0]    c_reg, c_next;
    logic [1:0]    sel_reg, sel_next;
    logic [7:0]    mn_reg [3];
    logic [7:0]    mn_next [3];
    logic [7:0]    mx_reg [3];
    logic [7:0]    mx_next [3];
    logic [BW-1:0] head_reg, head_next, tail_reg, tail_next, q_reg, q_next;
    logic [NW-1:0] boxes_reg, boxes_next, target_reg, target_next, k_reg, k_next;
    logic [SW-1:0] sum_reg [3];
    logic [SW-1:0] sum_next [3];
    logic [7:0]    mean_reg [3];
    logic [7:0]    mean_next [3];
    logic [1:0]    dch_reg, dch_next;
    logic          rv_reg, rv_next;
    mcp_pkg::result_t res_reg, res_next;

    logic          st_we, sc_we, bk_we, bx_we;
    logic [AW-1:0] st_waddr, sc_waddr;
    logic [23:0]   st_wdata, st_rdata, sc_rdata;
    logic [7:0]    bk_waddr, bk_raddr;
    logic [CW-1:0] bk_wdata, bk_rdata;
    logic [BW-1:0] bx_waddr, bx_raddr;
    logic [2*CW-1:0] bx_wdata, bx_rdata;

    logic          div_start, div_done;
    logic [SW-1:0] div_quo;
    logic [CW-1:0] cnt, mid;
    logic [10:0]   key, key_inv, key_min;
    logic [7:0]    ext [3];
    logic [6:0]    ps_clip;

    function automatic logic [BW-1:0] q_inc(input logic [BW-1:0] x);
        return (x == BW'(MAX_COLORS - 1)) ? '0 : x + BW'(1);
    endfunction

    mcp_ram #(.WIDTH(24), .DEPTH(MAX_PIXELS)) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(i_reg[AW-1:0]), .rdata(st_rdata)
    );

    mcp_ram #(.WIDTH(24), .DEPTH(MAX_PIXELS)) u_scratch (
        .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(px_reg),
        .raddr(i_reg[AW-1:0]), .rdata(sc_rdata)
    );

    mcp_ram #(.WIDTH(CW), .DEPTH(256)) u_bucket (
        .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
        .raddr(bk_raddr), .rdata(bk_rdata)
    );

    mcp_ram #(.WIDTH(2 * CW), .DEPTH(MAX_COLORS)) u_boxes (
        .clk(clk), .we(bx_we), .waddr(bx_waddr), .wdata(bx_wdata),
        .raddr(bx_raddr), .rdata(bx_rdata)
    );

    mcp_divider #(.DW(SW), .VW(CW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_reg[dch_reg]),
        .divisor(cnt), .done(div_done), .quotient(div_quo)
    );

    assign cnt       = hi_reg - lo_reg;
    assign mid       = lo_reg + (cnt >> 1);
    assign key       = {2'b00, st_rdata[23:16], 1'b0} + {3'b000, st_rdata[15:8]}
                     + {3'b000, st_rdata[7:0]} + {2'b00, st_rdata[7:0], 1'b0};
    assign key_inv   = mcp_pkg::KEY_SPAN - key;
    assign key_min   = (key < key_inv) ? key : key_inv;
    assign ps_clip   = (palette_size == 7'd0) ? 7'd1
                     : (palette_size > 7'(MAX_COLORS)) ? 7'(MAX_COLORS) : palette_size;
    assign item_take = (state_reg == S_IDLE) && item_valid;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ext[c] = (mx_reg[c] >= mn_reg[c]) ? mx_reg[c] - mn_reg[c] : 8'd0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        run_next    = run_reg;
        px_next     = px_reg;
        bkt_next    = bkt_reg;
        c_next      = c_reg;
        sel_next    = sel_reg;
        mn_next     = mn_reg;
        mx_next     = mx_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        q_next      = q_reg;
        boxes_next  = boxes_reg;
        target_next = target_reg;
        k_next      = k_reg;
        sum_next    = sum_reg;
        mean_next   = mean_reg;
        dch_next    = dch_reg;
        rv_next     = rv_reg && !res_take;
        res_next    = res_reg;

        st_we     = 1'b0;
        st_waddr  = count_reg[AW-1:0];
        st_wdata  = {item.red, item.green, item.blue};
        sc_we     = 1'b0;
        sc_waddr  = bk_rdata[AW-1:0];
        bk_we     = 1'b0;
        bk_waddr  = c_reg;
        bk_wdata  = '0;
        bk_raddr  = c_reg;
        bx_we     = 1'b0;
        bx_waddr  = tail_reg;
        bx_wdata  = {lo_reg, mid};
        bx_raddr  = head_reg;
        div_start = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (count_reg < CW'(MAX_PIXELS))
                    begin
                        st_we      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        i_next      = '0;
                        j_next      = '0;
                        target_next = NW'(ps_clip);
                        state_next  = (luma_min != 10'd0) ? S_TRIM_RD : S_INIT;
                    end
                end
            end
            S_TRIM_RD:
            begin
                if (i_reg == count_reg)
                begin
                    count_next = j_reg;
                    state_next = S_INIT;
                end
                else
                begin
                    state_next = S_TRIM_CHK;
                end
            end
            S_TRIM_CHK:
            begin
                if (key_min >= {1'b0, luma_min})
                begin
                    st_we    = 1'b1;
                    st_waddr = j_reg[AW-1:0];
                    st_wdata = st_rdata;
                    j_next   = j_reg + CW'(1);
                end
                i_next     = i_reg + CW'(1);
                state_next = S_TRIM_RD;
            end
            S_INIT:
            begin
                bx_we      = 1'b1;
                bx_waddr   = '0;
                bx_wdata   = {{CW{1'b0}}, count_reg};
                head_next  = '0;
                tail_next  = q_inc('0);
                boxes_next = NW'(1);
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (boxes_reg < target_reg)
                begin
                    state_next = S_BOX;
                end
                else
                begin
                    q_next     = head_reg;
                    k_next     = '0;
                    state_next = S_E_BOX;
                end
            end
            S_BOX:
            begin
                lo_next    = bx_rdata[2*CW-1:CW];
                hi_next    = bx_rdata[CW-1:0];
                i_next     = bx_rdata[2*CW-1:CW];
                head_next  = q_inc(head_reg);
                for (int c = 0; c < 3; c++)
                begin
                    mn_next[c] = 8'hFF;
                    mx_next[c] = 8'h00;
                end
                state_next = S_MM_RD;
            end
            S_MM_RD:
            begin
                state_next = (i_reg == hi_reg) ? S_AXIS : S_MM_USE;
            end
            S_MM_USE:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (mcp_pkg::chan_of(st_rdata, 2'(c)) < mn_reg[c])
                    begin
                        mn_next[c] = mcp_pkg::chan_of(st_rdata, 2'(c));
                    end
                    if (mcp_pkg::chan_of(st_rdata, 2'(c)) > mx_reg[c])
                    begin
                        mx_next[c] = mcp_pkg::chan_of(st_rdata, 2'(c));
                    end
                end
                i_next     = i_reg + CW'(1);
                state_next = S_MM_RD;
            end
            S_AXIS:
            begin
                priority if (ext[0] >= ext[1] && ext[0] >= ext[2])
                begin
                    sel_next = mcp_pkg::CH_RED;
                end
                else if (ext[1] >= ext[2])
                begin
                    sel_next = mcp_pkg::CH_GREEN;
                end
                else
                begin
                    sel_next = mcp_pkg::CH_BLUE;
                end
                c_next     = '0;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                bk_we  = 1'b1;
                c_next = c_reg + 8'd1;
                if (c_reg == 8'hFF)
                begin
                    i_next     = lo_reg;
                    state_next = S_H_RD;
                end
            end
            S_H_RD:
            begin
                if (i_reg == hi_reg)
                begin
                    c_next     = '0;
                    run_next   = lo_reg;
                    state_next = S_P_RD;
                end
                else
                begin
                    state_next = S_H_B;
                end
            end
            S_H_B:
            begin
                bk_raddr   = mcp_pkg::chan_of(st_rdata, sel_reg);
                bkt_next   = mcp_pkg::chan_of(st_rdata, sel_reg);
                state_next = S_H_W;
            end
            S_H_W:
            begin
                bk_we      = 1'b1;
                bk_waddr   = bkt_reg;
                bk_wdata   = bk_rdata + CW'(1);
                i_next     = i_reg + CW'(1);
                state_next = S_H_RD;
            end
            S_P_RD:
            begin
                state_next = S_P_W;
            end
            S_P_W:
            begin
                bk_we    = 1'b1;
                bk_wdata = run_reg;
                run_next = run_reg + bk_rdata;
                c_next   = c_reg + 8'd1;
                if (c_reg == 8'hFF)
                begin
                    i_next     = lo_reg;
                    state_next = S_S_RD;
                end
                else
                begin
                    state_next = S_P_RD;
                end
            end
            S_S_RD:
            begin
                if (i_reg == hi_reg)
                begin
                    i_next     = lo_reg;
                    state_next = S_C_RD;
                end
                else
                begin
                    state_next = S_S_B;
                end
            end
            S_S_B:
            begin
                bk_raddr   = mcp_pkg::chan_of(st_rdata, sel_reg);
                bkt_next   = mcp_pkg::chan_of(st_rdata, sel_reg);
                px_next    = st_rdata;
                state_next = S_S_W;
            end
            S_S_W:
            begin
                sc_we      = 1'b1;
                bk_we      = 1'b1;
                bk_waddr   = bkt_reg;
                bk_wdata   = bk_rdata + CW'(1);
                i_next     = i_reg + CW'(1);
                state_next = S_S_RD;
            end
            S_C_RD:
            begin
                state_next = (i_reg == hi_reg) ? S_WLO : S_C_W;
            end
            S_C_W:
            begin
                st_we      = 1'b1;
                st_waddr   = i_reg[AW-1:0];
                st_wdata   = sc_rdata;
                i_next     = i_reg + CW'(1);
                state_next = S_C_RD;
            end
            S_WLO:
            begin
                bx_we      = 1'b1;
                tail_next  = q_inc(tail_reg);
                state_next = S_WHI;
            end
            S_WHI:
            begin
                bx_we      = 1'b1;
                bx_wdata   = {mid, hi_reg};
                tail_next  = q_inc(tail_reg);
                boxes_next = boxes_reg + NW'(1);
                state_next = S_LOOP;
            end
            S_E_BOX:
            begin
                bx_raddr   = q_reg;
                state_next = S_E_GET;
            end
            S_E_GET:
            begin
                lo_next    = bx_rdata[2*CW-1:CW];
                hi_next    = bx_rdata[CW-1:0];
                i_next     = bx_rdata[2*CW-1:CW];
                for (int c = 0; c < 3; c++)
                begin
                    sum_next[c]  = '0;
                    mean_next[c] = 8'd0;
                end
                dch_next   = '0;
                state_next = S_E_RD;
            end
            S_E_RD:
            begin
                if (i_reg == hi_reg)
                begin
                    state_next = (cnt == '0) ? S_OUT : S_DIV_GO;
                end
                else
                begin
                    state_next = S_E_ACC;
                end
            end
            S_E_ACC:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sum_next[c] = sum_reg[c] + SW'(mcp_pkg::chan_of(st_rdata, 2'(c)));
                end
                i_next     = i_reg + CW'(1);
                state_next = S_E_RD;
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    mean_next[dch_reg] = div_quo[7:0];
                    if (dch_reg == 2'd2)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        dch_next   = dch_reg + 2'd1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_OUT:
            begin
                if (!rv_reg)
                begin
                    rv_next                 = 1'b1;
                    res_next.entry_index    = 6'(k_reg);
                    res_next.red_mean       = mean_reg[0];
                    res_next.green_mean     = mean_reg[1];
                    res_next.blue_mean      = mean_reg[2];
                    res_next.empty_box      = (cnt == '0);
                    res_next.pixels_dropped = ovf_reg;
                    res_next.last_entry     = ((k_reg + NW'(1)) == boxes_reg);
                    if ((k_reg + NW'(1)) == boxes_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + NW'(1);
                        q_next     = q_inc(q_reg);
                        state_next = S_E_BOX;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        run_reg    <= run_next;
        px_reg     <= px_next;
        bkt_reg    <= bkt_next;
        c_reg      <= c_next;
        sel_reg    <= sel_next;
        mn_reg     <= mn_next;
        mx_reg     <= mx_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        q_reg      <= q_next;
        boxes_reg  <= boxes_next;
        target_reg <= target_next;
        k_reg      <= k_next;
        sum_reg    <= sum_next;
        mean_reg   <= mean_next;
        dch_reg    <= dch_next;
        res_reg    <= res_next;
    end

endmodule

>>> hdl/median_cut_palette.sv
// Top level of the median-cut palette builder: config registers, front queue, engine.
// Depends on mcp_pkg, mcp_front, mcp_engine.
//
// Pixels enter one per cycle while the engine is idle, through a two-deep front queue,
// and are written straight into the pixel store. The item with last_pixel set starts
// the build, during which no pixel is taken: an optional trim pass (when luma_min is not
// zero), then palette_size-1 splits (palette_size clipped to 1..MAX_COLORS), each made of
// a min/max scan, a bucket clear, a histogram, a prefix sum, a scatter and a copy-back,
// all through registered-read RAMs, then per box a summing pass plus, for a box that is
// not empty, 3 serial divisions.
// Results wait in one output register.
module median_cut_palette #(
    parameter int MAX_PIXELS = 4096,
    parameter int MAX_COLORS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    input  logic       last_pixel,
    output logic       empty,
    input  logic       pop,
    output logic [5:0] entry_index,
    output logic [7:0] red_mean,
    output logic [7:0] green_mean,
    output logic [7:0] blue_mean,
    output logic       empty_box,
    output logic       pixels_dropped,
    output logic       last_entry,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [9:0] cfg_data
);

    logic [6:0]       palette_size_reg;
    logic [9:0]       luma_min_reg;
    mcp_pkg::pixel_t  px_in, px_q;
    logic             q_valid, q_take, res_valid;
    mcp_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign px_in     = '{last: last_pixel, red: red_in, green: green_in, blue: blue_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_size_reg <= 7'd8;
            luma_min_reg     <= 10'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mcp_pkg::CFG_PALETTE_SIZE: palette_size_reg <= cfg_data[6:0];
                mcp_pkg::CFG_LUMA_MIN:     luma_min_reg     <= cfg_data;
                default:                   palette_size_reg <= palette_size_reg;
            endcase
        end
    end

    mcp_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item_in(px_in),
        .item_valid(q_valid), .item_out(px_q), .item_take(q_take)
    );

    mcp_engine #(.MAX_PIXELS(MAX_PIXELS), .MAX_COLORS(MAX_COLORS)) u_engine (
        .clk(clk), .rst_n(rst_n), .item_valid(q_valid), .item(px_q), .item_take(q_take),
        .palette_size(palette_size_reg), .luma_min(luma_min_reg),
        .res_valid(res_valid), .res(res), .res_take(pop)
    );

    assign empty          = !res_valid;
    assign entry_index    = res.entry_index;
    assign red_mean       = res.red_mean;
    assign green_mean     = res.green_mean;
    assign blue_mean      = res.blue_mean;
    assign empty_box      = res.empty_box;
    assign pixels_dropped = res.pixels_dropped;
    assign last_entry     = res.last_entry;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(entry_index) && $stable(red_mean))
        else $error("waiting result changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && empty_box |-> red_mean == 8'd0 && green_mean == 8'd0 && blue_mean == 8'd0)
        else $error("empty box with nonzero colour");

    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop |=> empty)
        else $error("result register not cleared after pop");

endmodule
